/* rtl/sac_pkg.sv */
// Package for the slot shuffler: sizes, payload structs, microcode codes and program.
// Used by sac_seq, shuffle_avoiding_current_top and sac_checker; depends on nothing.
`default_nettype none

package sac_pkg;

   localparam int SLOTS      = 5;
   localparam int MAX_TRIES  = 64;
   localparam int IN_SLOTS   = 5;
   localparam int SLOT_W     = 4;
   localparam int TARGET_W   = 3;
   localparam int WORD_W     = 32;
   localparam int NIB_W      = 4;
   localparam int NIBBLES    = WORD_W / NIB_W;
   localparam int NIB_CNT_W  = $clog2(NIBBLES);
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int MOD_W      = $clog2(SLOTS + 1);
   localparam int TRY_W      = $clog2(MAX_TRIES + 1);
   localparam int REPORTED   = (SLOTS < IN_SLOTS) ? SLOTS : IN_SLOTS;

   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 5;
   localparam logic [WORD_W-1:0] SEED_RESET = 32'hDEADBEEF;

   // Datapath operations.
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
   localparam logic [OP_W-1:0] OP_DRAW  = 3'd2;
   localparam logic [OP_W-1:0] OP_MOD   = 3'd3;
   localparam logic [OP_W-1:0] OP_SWAP  = 3'd4;
   localparam logic [OP_W-1:0] OP_CHECK = 3'd5;
   localparam logic [OP_W-1:0] OP_EMIT  = 3'd6;

   // Jump conditions.
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] C_NO_REQ   = 3'd2;
   localparam logic [COND_W-1:0] C_NIB_MORE = 3'd3;
   localparam logic [COND_W-1:0] C_I_MORE   = 3'd4;
   localparam logic [COND_W-1:0] C_RETRY    = 3'd5;
   localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd6;

   // Program steps.
   localparam int UPC_W = 3;
   localparam logic [UPC_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [UPC_W-1:0] STEP_DRAW  = 3'd1;
   localparam logic [UPC_W-1:0] STEP_MOD   = 3'd2;
   localparam logic [UPC_W-1:0] STEP_SWAP  = 3'd3;
   localparam logic [UPC_W-1:0] STEP_CHECK = 3'd4;
   localparam logic [UPC_W-1:0] STEP_EMIT  = 3'd5;
   localparam logic [UPC_W-1:0] STEP_BACK  = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [UPC_W-1:0]  target;
   } uword_type;

   typedef struct packed {
      logic no_req;
      logic nib_more;
      logic i_more;
      logic retry;
      logic out_busy;
   } seq_status_type;

   typedef struct packed {
      logic [WORD_W-1:0]        entropy;
      logic signed [SLOT_W-1:0] slot_0_now;
      logic signed [SLOT_W-1:0] slot_1_now;
      logic signed [SLOT_W-1:0] slot_2_now;
      logic signed [SLOT_W-1:0] slot_3_now;
      logic signed [SLOT_W-1:0] slot_4_now;
   } req_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target_0;
      logic [TARGET_W-1:0] target_1;
      logic [TARGET_W-1:0] target_2;
      logic [TARGET_W-1:0] target_3;
      logic [TARGET_W-1:0] target_4;
      logic                gave_up;
   } rsp_type;

   // The control store. A taken condition jumps to target, otherwise the next step follows.
   function automatic uword_type microcode(input logic [UPC_W-1:0] step);
      uword_type w;
      unique case (step)
         STEP_IDLE:  w = '{op: OP_LOAD,  cond: C_NO_REQ,   target: STEP_IDLE};
         STEP_DRAW:  w = '{op: OP_DRAW,  cond: C_NEVER,    target: STEP_IDLE};
         STEP_MOD:   w = '{op: OP_MOD,   cond: C_NIB_MORE, target: STEP_MOD};
         STEP_SWAP:  w = '{op: OP_SWAP,  cond: C_I_MORE,   target: STEP_DRAW};
         STEP_CHECK: w = '{op: OP_CHECK, cond: C_RETRY,    target: STEP_DRAW};
         STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY, target: STEP_EMIT};
         STEP_BACK:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_IDLE};
         default:    w = '{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] x;
      x = s ^ (s << SHIFT_A);
      x = x ^ (x >> SHIFT_B);
      x = x ^ (x << SHIFT_C);
      return x;
   endfunction

endpackage

`default_nettype wire

/* rtl/sac_seq.sv */
// Microcode sequencer of the slot shuffler: step counter, control store and jump logic.
// Depends on sac_pkg.
`default_nettype none

module sac_seq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sac_pkg::seq_status_type  status,
   output logic [sac_pkg::OP_W-1:0]      op
);

   logic [sac_pkg::UPC_W-1:0] upc_ff;
   logic [sac_pkg::UPC_W-1:0] upc_in;
   sac_pkg::uword_type        uword;
   logic                      take;

   always_comb begin
      uword = sac_pkg::microcode(upc_ff);
      unique case (uword.cond)
         sac_pkg::C_NEVER:    take = 1'b0;
         sac_pkg::C_ALWAYS:   take = 1'b1;
         sac_pkg::C_NO_REQ:   take = status.no_req;
         sac_pkg::C_NIB_MORE: take = status.nib_more;
         sac_pkg::C_I_MORE:   take = status.i_more;
         sac_pkg::C_RETRY:    take = status.retry;
         sac_pkg::C_OUT_BUSY: take = status.out_busy;
         default:             take = 1'b0;
      endcase
      upc_in = take ? uword.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= sac_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign op = uword.op;

endmodule

`default_nettype wire

/* rtl/shuffle_avoiding_current_top.sv */
// Slot shuffler top level: datapath for seed, remainder unit and permutation registers.
// Depends on sac_pkg and sac_seq.
//
// Each accepted item XORs its entropy word into the kept xorshift32 seed and shuffles
// the slot permutation until no occupied slot keeps its current value, or until 64
// passes are used up (gave_up is then set and the targets are the last pass). A pass
// is four draws (each a generator step, eight remainder steps of the nibble-serial
// modulo unit and a swap) and one check. One item is worked on at a time; a finished
// result waits in the output register while the next item is taken in.
`default_nettype none

module shuffle_avoiding_current_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sac_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sac_pkg::rsp_type       rsp_payload
);

   localparam int IDX_W = sac_pkg::IDX_W;

   logic [sac_pkg::OP_W-1:0]      op;
   sac_pkg::seq_status_type       status;

   logic [sac_pkg::WORD_W-1:0]    seed_ff, seed_in;
   logic [sac_pkg::WORD_W-1:0]    word_ff, word_in;
   logic [IDX_W-1:0]              rem_ff, rem_in;
   logic [sac_pkg::NIB_CNT_W-1:0] nib_ff, nib_in;
   logic [IDX_W-1:0]              i_ff, i_in;
   logic [sac_pkg::TRY_W-1:0]     tries_ff, tries_in, tries_inc;
   logic                          ok_ff, ok_in, ok_now;
   logic [IDX_W-1:0]              perm_ff [sac_pkg::SLOTS];
   logic [IDX_W-1:0]              perm_in [sac_pkg::SLOTS];
   logic [sac_pkg::SLOT_W-1:0]    now_ff  [sac_pkg::IN_SLOTS];
   logic [sac_pkg::SLOT_W-1:0]    now_in  [sac_pkg::IN_SLOTS];
   logic [sac_pkg::TARGET_W-1:0]  target  [sac_pkg::IN_SLOTS];
   logic [sac_pkg::MOD_W-1:0]     modulus;
   sac_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_busy;

   // Folds one nibble into a remainder below m, one bit at a time.
   function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] rem,
                                                 input logic [sac_pkg::NIB_W-1:0] nib,
                                                 input logic [sac_pkg::MOD_W-1:0] m);
      logic [IDX_W:0] acc;
      logic [IDX_W:0] mw;
      acc = {1'b0, rem};
      mw  = (IDX_W + 1)'(m);
      for (int b = sac_pkg::NIB_W - 1; b >= 0; b--) begin
         acc = {acc[IDX_W-1:0], nib[b]};
         if (acc >= mw) begin
            acc = acc - mw;
         end
      end
      return acc[IDX_W-1:0];
   endfunction

   sac_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   assign modulus   = sac_pkg::MOD_W'(i_ff) + sac_pkg::MOD_W'(1);
   assign tries_inc = tries_ff + 1'b1;
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   // A pass is accepted when no occupied slot keeps its value; an empty slot (all ones)
   // can never equal a permutation entry.
   always_comb begin
      ok_now = 1'b1;
      for (int s = 0; s < sac_pkg::REPORTED; s++) begin
         if (now_ff[s] == sac_pkg::SLOT_W'(perm_ff[s])) begin
            ok_now = 1'b0;
         end
      end
   end

   for (genvar k = 0; k < sac_pkg::IN_SLOTS; k++) begin : g_target
      if (k < sac_pkg::SLOTS) begin : g_used
         assign target[k] = sac_pkg::TARGET_W'(perm_ff[k]);
      end else begin : g_unused
         assign target[k] = '0;
      end
   end

   always_comb begin
      status.no_req   = !req_valid;
      status.nib_more = nib_ff != sac_pkg::NIB_CNT_W'(sac_pkg::NIBBLES - 1);
      status.i_more   = i_ff > IDX_W'(1);
      status.retry    = !ok_now && (tries_inc < sac_pkg::TRY_W'(sac_pkg::MAX_TRIES));
      status.out_busy = out_busy;
   end

   always_comb begin
      now_in[0] = req_payload.slot_0_now;
      now_in[1] = req_payload.slot_1_now;
      now_in[2] = req_payload.slot_2_now;
      now_in[3] = req_payload.slot_3_now;
      now_in[4] = req_payload.slot_4_now;

      rsp_in.target_0 = target[0];
      rsp_in.target_1 = target[1];
      rsp_in.target_2 = target[2];
      rsp_in.target_3 = target[3];
      rsp_in.target_4 = target[4];
      rsp_in.gave_up  = !ok_ff;
   end

   always_comb begin
      seed_in      = seed_ff;
      word_in      = word_ff;
      rem_in       = rem_ff;
      nib_in       = nib_ff;
      i_in         = i_ff;
      tries_in     = tries_ff;
      ok_in        = ok_ff;
      perm_in      = perm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (op)
         sac_pkg::OP_LOAD: begin
            if (req_valid) begin
               seed_in  = seed_ff ^ req_payload.entropy;
               tries_in = '0;
               i_in     = IDX_W'(sac_pkg::SLOTS - 1);
               for (int k = 0; k < sac_pkg::SLOTS; k++) begin
                  perm_in[k] = IDX_W'(k);
               end
            end
         end
         sac_pkg::OP_DRAW: begin
            seed_in = sac_pkg::xorshift32(seed_ff);
            word_in = sac_pkg::xorshift32(seed_ff);
            rem_in  = '0;
            nib_in  = '0;
         end
         sac_pkg::OP_MOD: begin
            rem_in  = mod_step(rem_ff, word_ff[sac_pkg::WORD_W-1 -: sac_pkg::NIB_W], modulus);
            word_in = word_ff << sac_pkg::NIB_W;
            nib_in  = nib_ff + 1'b1;
         end
         sac_pkg::OP_SWAP: begin
            perm_in[i_ff]   = perm_ff[rem_ff];
            perm_in[rem_ff] = perm_ff[i_ff];
            i_in            = i_ff - 1'b1;
         end
         sac_pkg::OP_CHECK: begin
            ok_in    = ok_now;
            tries_in = tries_inc;
            i_in     = IDX_W'(sac_pkg::SLOTS - 1);
         end
         sac_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= sac_pkg::SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      rem_ff   <= rem_in;
      nib_ff   <= nib_in;
      i_ff     <= i_in;
      tries_ff <= tries_in;
      ok_ff    <= ok_in;
      perm_ff  <= perm_in;
      if (op == sac_pkg::OP_LOAD && req_valid) begin
         now_ff <= now_in;
      end
      if (op == sac_pkg::OP_EMIT && !out_busy) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready   = op == sac_pkg::OP_LOAD;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* rtl/sac_checker.sv */
// Port-level checks for the slot shuffler, bound to shuffle_avoiding_current_top.
// Depends on sac_pkg.
`default_nettype none

module sac_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire sac_pkg::req_type  req_payload,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire sac_pkg::rsp_type  rsp_payload
);

   localparam int MASK_W = 1 << sac_pkg::TARGET_W;
   localparam logic [MASK_W-1:0] FULL = MASK_W'((1 << sac_pkg::SLOTS) - 1);

   logic [sac_pkg::TARGET_W-1:0] target [sac_pkg::IN_SLOTS];
   logic [MASK_W-1:0]            seen;
   logic                         perm_ok;
   logic [sac_pkg::WORD_W-1:0]   unused_entropy;

   assign unused_entropy = req_payload.entropy;

   // The reported targets must be distinct values of the permutation range.
   always_comb begin
      target[0] = rsp_payload.target_0;
      target[1] = rsp_payload.target_1;
      target[2] = rsp_payload.target_2;
      target[3] = rsp_payload.target_3;
      target[4] = rsp_payload.target_4;
      seen = '0;
      for (int k = 0; k < sac_pkg::REPORTED; k++) begin
         seen[target[k]] = 1'b1;
      end
      perm_ok = ($countones(seen) == sac_pkg::REPORTED) && ((seen & ~FULL) == '0);
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed or dropped while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item taken while one is still being shuffled");

   a_perm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> perm_ok)
      else $error("result targets are not a permutation");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle and empty after reset");

endmodule

bind shuffle_avoiding_current_top sac_checker u_checker (.*);

`default_nettype wire
